FILE: rtl/ftda_pkg.sv
package ftda_pkg;

   localparam int INT_DIGITS = 10;
   localparam int DIGIT_IDX_W = $clog2(INT_DIGITS);

   localparam logic [31:0] SAT_INT = 32'd2147483647;
   // ceil(2^35 / 10): exact quotient by 10 for any 32-bit dividend
   localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_SAT = 2'd1;
   localparam logic [1:0] STATUS_NAN = 2'd2;
   localparam logic [1:0] STATUS_BAD = 2'd3;

   localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
   localparam logic [7:0] EXP_SAT      = 8'd158;
   localparam logic [7:0] EXP_INT_ONLY = 8'd150;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_INT,
      ST_DOT,
      ST_FRAC
   } ftda_state_type;

endpackage

FILE: rtl/float_to_decimal_ascii_core.sv
// Sequence: accept, then one divide-by-ten step per integer digit (1..10), then one
// character per cycle while rsp is not stalled: optional sign, integer digits, point,
// fraction digits. A new float is taken only back in idle, after its last fraction digit
// is issued; the divide loop and the char sequencer set the pace.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
module float_to_decimal_ascii_core #(
   parameter int FRACTION_DIGITS = 6,
   parameter int FRACTION_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_float_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_ascii_char,
   output logic        rsp_last_char,
   output logic [1:0]  rsp_status
);
   import ftda_pkg::*;

   localparam int FB  = FRACTION_BITS;
   localparam int FCW = $clog2(FRACTION_DIGITS + 1);

   ftda_state_type state_ff, state_in;

   logic [31:0]          ipart_ff, ipart_in;
   logic [FB-1:0]        frac_ff, frac_in;
   logic [1:0]           status_ff, status_in;
   logic                 neg_ff, neg_in;
   logic [3:0]           digit_ff [INT_DIGITS];
   logic [3:0]           digit_in [INT_DIGITS];
   logic [DIGIT_IDX_W:0] ptr_ff, ptr_in;
   logic [FCW-1:0]       fcnt_ff, fcnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   // decode of the incoming float
   logic        sgn;
   logic [7:0]  ex;
   logic [22:0] man;
   logic        is_nan;
   logic [23:0] m;
   logic [7:0]  e;
   logic [87:0] shx;
   logic [31:0] d_ipart;
   logic [FB-1:0] d_frac;
   logic [1:0]  d_status;
   logic        d_neg;

   assign sgn    = req_float_bits[31];
   assign ex     = req_float_bits[30:23];
   assign man    = req_float_bits[22:0];
   assign is_nan = (ex == EXP_ALL_ONES) && (man != 23'd0);
   assign m      = {ex != 8'd0, man};
   assign e      = (ex == 8'd0) ? 8'd1 : ex;

   always_comb begin
      d_ipart  = '0;
      d_frac   = '0;
      d_status = STATUS_OK;
      d_neg    = 1'b0;
      shx      = '0;
      if (is_nan) begin
         d_status = STATUS_NAN;
      end else begin
         d_neg = sgn && (req_float_bits[30:0] != 31'd0);
         if (ex >= EXP_SAT) begin
            d_ipart  = SAT_INT;
            d_status = STATUS_SAT;
         end else if (e >= EXP_INT_ONLY) begin
            d_ipart = {8'd0, m} << (e - EXP_INT_ONLY);
         end else begin
            shx     = {m, 64'd0} >> (EXP_INT_ONLY - e);
            d_ipart = {8'd0, shx[87:64]};
            d_frac  = shx[63 -: FB];
         end
      end
   end

   logic [31:0] div_q;
   logic [3:0]  div_r;

   ftda_div10 u_div10 (
      .dividend  (ipart_ff),
      .quotient  (div_q),
      .remainder (div_r)
   );

   logic [FB+3:0]          frac_x10;
   logic [DIGIT_IDX_W-1:0] rd_idx;
   logic                   out_free;

   assign frac_x10 = {1'b0, frac_ff, 3'd0} + {3'd0, frac_ff, 1'b0};
   assign rd_idx   = DIGIT_IDX_W'(ptr_ff - 1'b1);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ipart_ff      <= ipart_in;
      frac_ff       <= frac_in;
      status_ff     <= status_in;
      neg_ff        <= neg_in;
      digit_ff      <= digit_in;
      ptr_ff        <= ptr_in;
      fcnt_ff       <= fcnt_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      ipart_in      = ipart_ff;
      frac_in       = frac_ff;
      status_in     = status_ff;
      neg_in        = neg_ff;
      digit_in      = digit_ff;
      ptr_in        = ptr_ff;
      fcnt_in       = fcnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      req_ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ipart_in  = d_ipart;
               frac_in   = d_frac;
               status_in = d_status;
               neg_in    = d_neg;
               ptr_in    = '0;
               fcnt_in   = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            // digits land least significant first; emitted back to front
            digit_in[DIGIT_IDX_W'(ptr_ff)] = div_r;
            ptr_in   = ptr_ff + 1'b1;
            ipart_in = div_q;
            if (div_q == 32'd0) begin
               state_in = neg_ff ? ST_SIGN : ST_INT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = CHAR_MINUS;
               rsp_last_in   = 1'b0;
               rsp_status_in = status_ff;
               state_in      = ST_INT;
            end
         end
         ST_INT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = CHAR_ZERO + {4'd0, digit_ff[rd_idx]};
               rsp_last_in   = 1'b0;
               rsp_status_in = status_ff;
               ptr_in        = ptr_ff - 1'b1;
               if (ptr_ff == (DIGIT_IDX_W+1)'(1)) begin
                  state_in = ST_DOT;
               end
            end
         end
         ST_DOT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = CHAR_DOT;
               rsp_last_in   = 1'b0;
               rsp_status_in = status_ff;
               state_in      = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = CHAR_ZERO + {4'd0, frac_x10[FB+3:FB]};
               rsp_status_in = status_ff;
               frac_in       = frac_x10[FB-1:0];
               fcnt_in       = fcnt_ff + 1'b1;
               rsp_last_in   = (fcnt_ff == FCW'(FRACTION_DIGITS - 1));
               if (fcnt_ff == FCW'(FRACTION_DIGITS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

FILE: rtl/ftda_div10.sv
module ftda_div10 (
   input  logic [31:0] dividend,
   output logic [31:0] quotient,
   output logic [3:0]  remainder
);
   import ftda_pkg::*;

   logic [63:0] prod;
   logic [28:0] quo;
   logic [31:0] quo_x10;
   logic [31:0] rem_full;

   assign prod     = {32'd0, dividend} * {32'd0, RECIP10};
   assign quo      = prod[63:35];
   assign quo_x10  = {quo, 3'd0} + {2'd0, quo, 1'b0};
   assign rem_full = dividend - quo_x10;
   assign quotient  = {3'd0, quo};
   assign remainder = rem_full[3:0];

endmodule

FILE: rtl/ftda_checker.sv
module ftda_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [31:0] req_float_bits,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_ascii_char,
   input logic        rsp_last_char,
   input logic [1:0]  rsp_status
);
   import ftda_pkg::*;

   // a stalled item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ascii_char)
         && $stable(rsp_last_char) && $stable(rsp_status))
      else $error("rsp item changed while stalled");

   // an accepted item drops req_ready as the block enters the divide state
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after accept");

   // the text always ends on a fraction digit
   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_ascii_char >= CHAR_ZERO
         && rsp_ascii_char <= CHAR_NINE)
      else $error("last char is not a digit");

   // NaN never shows a sign, and no unused status code appears
   a_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != STATUS_BAD
         && !(rsp_status == STATUS_NAN && rsp_ascii_char == CHAR_MINUS))
      else $error("bad status or signed NaN");

endmodule

bind float_to_decimal_ascii_core ftda_checker u_ftda_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import ftda_pkg::*;

   localparam int FRAC_DIGITS   = 6;
   localparam int FRAC_BITS     = 32;
   localparam int RANDOM_ITEMS  = 425;
   localparam int DRAIN_CYCLES  = 40;
   localparam int STALL_LIMIT   = 1000;

   localparam logic [31:0] CORNER_FLOATS [25] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'hBF00_0000,
      32'hB380_0000, 32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h0080_0000,
      32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
      32'h4F00_0000, 32'hCF00_0000, 32'h4EFF_FFFF, 32'hCEFF_FFFF, 32'h7F7F_FFFF,
      32'h4B00_0000, 32'h4AFF_FFFF, 32'h3DCC_CCCD, 32'h3F7F_FFFF, 32'hC2F6_E979
   };

   typedef struct packed {
      logic [7:0] ascii_char;
      logic       last_char;
      logic [1:0] status;
   } text_char_type;

   class decimal_text_scoreboard;
      text_char_type pending_chars[$];
      int unsigned   mismatch_count;

      function void expect_char(logic [7:0] ch, logic last, logic [1:0] st);
         text_char_type c;
         c.ascii_char = ch;
         c.last_char  = last;
         c.status     = st;
         pending_chars.push_back(c);
      endfunction

      // Spell out the decimal text of one float and queue its characters.
      function void note_number(logic [31:0] bits);
         logic [7:0]   exp_field;
         logic [23:0]  sig;
         logic [127:0] fixed_val;
         logic [31:0]  whole_val;
         logic [31:0]  rem;
         logic [63:0]  frac;
         logic [67:0]  prod;
         logic [1:0]   st;
         logic         show_minus;
         logic [7:0]   int_chars[$];
         int           shift;
         exp_field  = bits[30:23];
         whole_val  = '0;
         frac       = '0;
         st         = STATUS_OK;
         show_minus = 1'b0;
         int_chars  = {};
         if (exp_field == EXP_ALL_ONES && bits[22:0] != 0) begin
            st = STATUS_NAN;
         end else begin
            show_minus = bits[31] && (bits[30:0] != 0);
            if (exp_field >= EXP_SAT) begin
               whole_val = SAT_INT;
               st = STATUS_SAT;
            end else begin
               // subnormals: exponent 1, no hidden bit
               sig   = (exp_field == 0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
               shift = 150 - ((exp_field == 0) ? 1 : int'(exp_field));
               if (shift <= 0) begin
                  whole_val = {8'b0, sig} << (-shift);
               end else begin
                  // binary point between bit 64 and 63
                  fixed_val = {40'b0, sig, 64'b0} >> shift;
                  whole_val = fixed_val[95:64];
                  frac      = fixed_val[63:0];
                  frac      = frac & ~((64'd1 << (64 - FRAC_BITS)) - 64'd1);
               end
            end
         end
         do begin
            rem = whole_val % 10;
            int_chars.push_front(CHAR_ZERO + rem[7:0]);
            whole_val = whole_val / 10;
         end while (whole_val != 0);
         if (show_minus) expect_char(CHAR_MINUS, 1'b0, st);
         foreach (int_chars[i]) expect_char(int_chars[i], 1'b0, st);
         expect_char(CHAR_DOT, 1'b0, st);
         for (int i = 0; i < FRAC_DIGITS; i++) begin
            prod = {4'b0, frac} * 68'd10;
            frac = prod[63:0];
            expect_char(CHAR_ZERO + {4'b0, prod[67:64]}, i == FRAC_DIGITS - 1, st);
         end
      endfunction

      function void check_char(logic [7:0] ch, logic last, logic [1:0] st);
         text_char_type want;
         if (pending_chars.size() == 0) begin
            $error("ascii_char: expected nothing, got %h", ch);
            mismatch_count++;
            return;
         end
         want = pending_chars.pop_front();
         if (want.ascii_char !== ch) begin
            $error("ascii_char: expected %h, got %h", want.ascii_char, ch);
            mismatch_count++;
         end
         if (want.last_char !== last) begin
            $error("last_char: expected %b, got %b", want.last_char, last);
            mismatch_count++;
         end
         if (want.status !== st) begin
            $error("status: expected %0d, got %0d", want.status, st);
            mismatch_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_float_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_ascii_char;
   logic        rsp_last_char;
   logic [1:0]  rsp_status;
   logic        steady = 1'b0;
   int          quiet_cycles = 0;

   decimal_text_scoreboard book = new();

   always #2 clock = ~clock;

   float_to_decimal_ascii_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_float_bits (req_float_bits),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char),
      .rsp_status     (rsp_status)
   );

   // Random floats weighted toward the interesting exponent ranges.
   function automatic logic [31:0] random_float();
      logic [7:0]  e;
      logic [22:0] m;
      logic [31:0] raw;
      raw = $urandom();
      m   = raw[22:0];
      case ($urandom_range(9))
         0, 1: e = raw[30:23];
         2, 3, 4: e = 8'($urandom_range(160, 100));
         5, 6: e = 8'($urandom_range(130, 118));
         7: e = 8'($urandom_range(158, 148));
         8: begin
            e = ($urandom_range(1) != 0) ? EXP_ALL_ONES : 8'h00;
            if ($urandom_range(3) == 0) m = '0;
         end
         default: e = 8'($urandom_range(5, 0));
      endcase
      return {raw[31], e, m};
   endfunction

   task automatic send_number(input logic [31:0] bits);
      while (!steady && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_float_bits <= bits;
      do @(posedge clock); while (!req_ready);
      book.note_number(bits);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_char(rsp_ascii_char, rsp_last_char, rsp_status);
      rsp_ready <= steady || ($urandom_range(99) >= 22);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (CORNER_FLOATS[i]) send_number(CORNER_FLOATS[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // one long window with no stalls on either side
         steady <= (n >= 150 && n < 260);
         send_number(random_float());
      end
      req_valid <= 1'b0;
      steady    <= 1'b0;
      while (book.pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatch_count == 0 && book.pending_chars.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ftda_pkg.sv
rtl/ftda_div10.sv
rtl/float_to_decimal_ascii_core.sv
rtl/ftda_checker.sv
sim/tb_top.sv
